### rtl/opt_pkg.sv
// types and codes shared by the timer bank cells and top level
package opt_pkg;

	localparam int unsigned SecW    = 32;
	localparam int unsigned SelW    = 8;
	localparam int unsigned TagW    = 16;
	localparam int unsigned SlotW   = 4;
	localparam int unsigned CntW    = 5;
	localparam logic [CntW-1:0] MaxExp = 5'd16;

	typedef enum logic [1:0] {
		OP_START_ONE = 2'd0,
		OP_START_PER = 2'd1,
		OP_STOP      = 2'd2,
		OP_TICK      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_STOP   = 2'd1,
		KIND_EXPIRY = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	// command walking the cell row
	typedef struct packed {
		logic             valid;
		op_t              op;
		logic [SecW-1:0]  secs;
		logic [SelW-1:0]  sel;
		logic [TagW-1:0]  tag;
		logic             hit;
		logic [SlotW-1:0] slot;
		logic [CntW-1:0]  n_exp;
	} tok_t;

	// expiry raised by one cell
	typedef struct packed {
		logic             valid;
		logic [SlotW-1:0] slot;
		logic [TagW-1:0]  tag;
	} emit_t;

endpackage

### rtl/opt_cell.sv
// one timer slot: holds its count, reload, marks and tag, passes the command on
module opt_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  opt_pkg::tok_t tok_in,
	output opt_pkg::tok_t tok_out,
	output opt_pkg::emit_t emit
);
	import opt_pkg::*;

	tok_t            tok_q;
	logic [SecW-1:0] rem_q;
	logic [SecW-1:0] rel_q;
	logic            per_q;
	logic            act_q;
	logic [TagW-1:0] tag_q;

	logic [SecW-1:0] rem_dec;
	logic            expire;
	logic            do_start;
	logic            do_stop;

	always_comb begin
		rem_dec  = rem_q - SecW'(1);
		expire   = tok_q.valid && (tok_q.op == OP_TICK) && (rem_q != '0) && (rem_dec == '0);
		do_start = tok_q.valid && (tok_q.op == OP_START_ONE || tok_q.op == OP_START_PER)
			&& !tok_q.hit && !act_q;
		do_stop  = tok_q.valid && (tok_q.op == OP_STOP) && (tok_q.sel == SelW'(INDEX)) && act_q;
	end

	always_comb begin
		tok_out = tok_q;
		emit    = '0;
		if (do_start || do_stop) begin
			tok_out.hit  = 1'b1;
			tok_out.slot = SlotW'(INDEX);
		end
		if (expire && tok_q.n_exp < MaxExp) begin
			tok_out.n_exp = tok_q.n_exp + CntW'(1);
			emit.valid    = 1'b1;
			emit.slot     = SlotW'(INDEX);
			emit.tag      = tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rel_q <= '0;
			per_q <= 1'b0;
			act_q <= 1'b0;
			tag_q <= '0;
		end else if (advance && tok_q.valid) begin
			if (do_start) begin
				rem_q <= tok_q.secs;
				rel_q <= tok_q.secs;
				tag_q <= tok_q.tag;
				per_q <= (tok_q.op == OP_START_PER);
				act_q <= 1'b1;
			end else if (do_stop) begin
				rem_q <= '0;
				act_q <= 1'b0;
			end else if (tok_q.op == OP_TICK && rem_q != '0) begin
				if (expire) begin
					// periodic slots reload, one-shot slots retire
					if (per_q) begin
						rem_q <= rel_q;
					end else begin
						rem_q <= '0;
						act_q <= 1'b0;
					end
				end else begin
					rem_q <= rem_dec;
				end
			end
		end
	end

endmodule

### rtl/oneshot_periodic_timer_bank.sv
// timer bank top level: input beat, row of slot cells, result register
//
// Input beats carry a command in s_tuser: start one-shot, start periodic,
// stop a slot, or a tick. Output beats carry a kind in m_tuser, with
// m_tlast high on the final beat caused by one input beat.
// A command walks the row of SLOTS cells, one cell per cycle while the row
// is not held, then a tail stage issues the closing reply. A start takes
// the lowest free slot, a stop frees the selected slot, a tick counts every
// running slot down and sends an expiry beat, in slot order, from each cell
// whose count reaches zero. One command is in the row at a time, so a new
// input beat is taken only after the closing reply leaves the tail stage.
// The result register lets the next input beat be taken while the closing
// beat still waits.
// When m_tready is low with a beat waiting and another must be sent, the
// whole row holds until the beat is taken; nothing is dropped.
// Reset clears all counts, reloads, marks and tags and empties the row.
module oneshot_periodic_timer_bank #(
	parameter int unsigned SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // seconds[31:0], slot_select[39:32], owner_tag[55:40]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // slot_number[3:0], ok[4], expired_tag[20:5], zero[23:21]
	output logic [1:0]  m_tuser,  // kind[1:0]
	output logic        m_tlast
);
	import opt_pkg::*;

	tok_t  chain [SLOTS+1];
	emit_t emits [SLOTS];
	tok_t  tail_q;
	logic  busy_q;
	logic  advance;
	logic  accept;
	emit_t cell_emit;
	logic  emit_any;

	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [SlotW-1:0]  out_slot_q;
	logic              out_ok_q;
	logic [TagW-1:0]   out_tag_q;
	logic              out_last_q;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		chain[0]       = '0;
		chain[0].valid = accept;
		chain[0].op    = op_t'(s_tuser);
		chain[0].secs  = s_tdata[31:0];
		chain[0].sel   = s_tdata[39:32];
		chain[0].tag   = s_tdata[55:40];
	end

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		opt_cell #(.INDEX(k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1]),
			.emit    (emits[k])
		);
	end

	// only the cell holding the command can raise an expiry
	always_comb begin
		cell_emit = '0;
		for (int k = 0; k < SLOTS; k++) begin
			cell_emit = cell_emit | emits[k];
		end
	end

	assign emit_any = cell_emit.valid || tail_q.valid;
	assign advance  = !emit_any || !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (advance) begin
				tail_q <= chain[SLOTS];
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail_q.valid && advance) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any && advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_any && advance) begin
			if (cell_emit.valid) begin
				out_kind_q <= KIND_EXPIRY;
				out_slot_q <= cell_emit.slot;
				out_ok_q   <= 1'b1;
				out_tag_q  <= cell_emit.tag;
				out_last_q <= 1'b0;
			end else begin
				unique case (tail_q.op)
					OP_START_ONE, OP_START_PER: out_kind_q <= KIND_START;
					OP_STOP:                    out_kind_q <= KIND_STOP;
					OP_TICK:                    out_kind_q <= KIND_DONE;
					default:                    out_kind_q <= KIND_DONE;
				endcase
				out_slot_q <= tail_q.hit ? tail_q.slot : '0;
				out_ok_q   <= (tail_q.op == OP_TICK) || tail_q.hit;
				out_tag_q  <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_tag_q, out_ok_q, out_slot_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	logic [SLOTS:0] tok_valid;
	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			tok_valid[k] = chain[k+1].valid;
		end
		tok_valid[SLOTS] = tail_q.valid;
	end

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one command in the cell row");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !emit_any)
		else $error("beat raised while no command is held");

	a_tail_alone: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q.valid |-> !cell_emit.valid)
		else $error("expiry raised while the closing reply is due");

endmodule

### test/tb.sv
// self-checking bench for the timer bank: directed and random commands, stalls, scoreboard
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import opt_pkg::*;

	localparam int unsigned NumSlots   = 16;
	localparam int unsigned HalfPeriod = 10;
	localparam int unsigned RandomCmds = 300;
	localparam int unsigned HoldCycles = 400;
	localparam int unsigned CycleLimit = 400000;

	typedef struct packed {
		kind_t            kind;
		logic [SlotW-1:0] slot;
		logic             ok;
		logic [TagW-1:0]  tag;
		logic             last;
	} bank_beat_t;

	class timer_bank_scoreboard;
		logic [SecW-1:0] count_left [NumSlots];
		logic [SecW-1:0] reload_val [NumSlots];
		logic [TagW-1:0] owner      [NumSlots];
		bit              periodic   [NumSlots];
		bit              busy       [NumSlots];
		bank_beat_t      awaited[$];
		int errors, starts, full_replies, stops, refused_stops, ticks, expiries;

		function new();
			for (int s = 0; s < NumSlots; s++) begin
				count_left[s] = '0;
				reload_val[s] = '0;
				owner[s]      = '0;
				periodic[s]   = 1'b0;
				busy[s]       = 1'b0;
			end
		endfunction

		function void await_beat(kind_t kind, int slot, bit ok, logic [TagW-1:0] tag, bit last);
			bank_beat_t b;
			b.kind = kind;
			b.slot = slot[SlotW-1:0];
			b.ok   = ok;
			b.tag  = tag;
			b.last = last;
			awaited.push_back(b);
		endfunction

		// one accepted command: update the slot state and queue the beats it causes
		function void note_command(op_t op, logic [SecW-1:0] secs, logic [SelW-1:0] sel,
				logic [TagW-1:0] tag);
			int slot, fired;
			case (op)
				OP_START_ONE, OP_START_PER: begin
					starts++;
					slot = -1;
					for (int s = 0; s < NumSlots; s++)
						if (slot < 0 && !busy[s]) slot = s;
					if (slot < 0) begin
						full_replies++;
						await_beat(KIND_START, 0, 1'b0, '0, 1'b1);
					end else begin
						count_left[slot] = secs;
						reload_val[slot] = secs;
						owner[slot]      = tag;
						periodic[slot]   = (op == OP_START_PER);
						busy[slot]       = 1'b1;
						await_beat(KIND_START, slot, 1'b1, '0, 1'b1);
					end
				end
				OP_STOP: begin
					stops++;
					if (sel < NumSlots && busy[sel]) begin
						count_left[sel] = '0;
						busy[sel]       = 1'b0;
						await_beat(KIND_STOP, sel, 1'b1, '0, 1'b1);
					end else begin
						refused_stops++;
						await_beat(KIND_STOP, 0, 1'b0, '0, 1'b1);
					end
				end
				default: begin
					ticks++;
					fired = 0;
					for (int s = 0; s < NumSlots; s++) begin
						if (count_left[s] != 0) begin
							count_left[s]--;
							if (count_left[s] == 0) begin
								if (periodic[s]) count_left[s] = reload_val[s];
								else busy[s] = 1'b0;
								if (fired < MaxExp) begin
									await_beat(KIND_EXPIRY, s, 1'b1, owner[s], 1'b0);
									fired++;
									expiries++;
								end
							end
						end
					end
					await_beat(KIND_DONE, 0, 1'b1, '0, 1'b1);
				end
			endcase
		endfunction

		function void report(string field, longint unsigned want, longint unsigned got);
			$display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
			errors++;
		endfunction

		function void check_beat(logic [1:0] kind, logic [SlotW-1:0] slot, logic ok,
				logic [TagW-1:0] tag, logic [2:0] pad, logic last);
			bank_beat_t want;
			if (awaited.size() == 0) begin
				$display("%0t: beat with nothing expected: expected none, actual kind %0d slot %0d",
					$time, kind, slot);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (kind !== want.kind) report("kind", want.kind, kind);
			if (slot !== want.slot) report("slot_number", want.slot, slot);
			if (ok !== want.ok) report("ok", want.ok, ok);
			if (tag !== want.tag) report("expired_tag", want.tag, tag);
			if (pad !== 3'b000) report("tdata padding", 0, pad);
			if (last !== want.last) report("tlast", want.last, last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	timer_bank_scoreboard sb = new();
	int burst_left = 1;
	int sent_count = 0;
	int cycles = 0;

	oneshot_periodic_timer_bank #(.SLOTS(NumSlots)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #(HalfPeriod) clk = ~clk;

	// offer one command and hold it until taken; may idle between bursts
	task automatic offer(input op_t op, input logic [SecW-1:0] secs, input logic [SelW-1:0] sel,
			input logic [TagW-1:0] tag);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {tag, sel, secs};
		do @(posedge clk); while (!s_tready);
		sent_count++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
		end
	endtask

	task automatic random_command();
		int pick;
		op_t op;
		logic [SecW-1:0] secs;
		logic [SelW-1:0] sel;
		pick = $urandom_range(0, 99);
		secs = $urandom();
		sel  = SelW'($urandom_range(0, 255));
		if (pick < 35) begin
			op = (pick < 17) ? OP_START_ONE : OP_START_PER;
			// mostly short counts so slots keep expiring; zero and huge now and then
			case ($urandom_range(0, 9))
				0:       secs = '0;
				1, 2:    secs = $urandom();
				default: secs = $urandom_range(1, 6);
			endcase
		end else if (pick < 60) begin
			op = OP_STOP;
			if ($urandom_range(0, 4) != 0) sel = SelW'($urandom_range(0, NumSlots - 1));
		end else begin
			op = OP_TICK;
		end
		offer(op, secs, sel, TagW'($urandom_range(0, 65535)));
	endtask

	// accepted command beats go to the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_command(op_t'(s_tuser), s_tdata[31:0], s_tdata[39:32], s_tdata[55:40]);
	end

	// accepted result beats are checked in order
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tuser, m_tdata[3:0], m_tdata[4], m_tdata[20:5], m_tdata[23:21], m_tlast);
	end

	// receiver: runs of always-ready, random stalls and a fixed pattern, one long hold-off
	initial begin : receiver
		int mode, run, k;
		bit held;
		m_tready = 1'b0;
		held = 1'b0;
		k = 0;
		forever begin
			mode = $urandom_range(0, 2);
			run  = $urandom_range(10, 80);
			if (!held && sent_count >= 60) begin
				held = 1'b1;
				mode = 3;
				run  = HoldCycles;
			end
			repeat (run) begin
				@(posedge clk);
				k++;
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 3) != 0);
					2:       m_tready <= ((k % 5) < 2);
					default: m_tready <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		logic [TagW-1:0] tag;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_TICK;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty bank: tick with no expiry, stops of an inactive and an out-of-range slot
		offer(OP_TICK, '0, '0, '0);
		offer(OP_STOP, 32'hFFFF_FFFF, 8'd0, 16'hFFFF);
		offer(OP_STOP, '0, 8'd255, '0);
		// fill every slot with count one, one-shot and periodic alternating
		for (i = 0; i < NumSlots; i++) begin
			tag = (i == 0) ? 16'hFFFF : (i == NumSlots - 1) ? 16'h0000 : TagW'(16'hA500 + i);
			offer((i % 2) ? OP_START_PER : OP_START_ONE, 32'd1, SelW'(i * 17), tag);
		end
		// bank full, then a tick that expires every slot at once
		offer(OP_START_PER, 32'd3, 8'hFF, 16'h1234);
		offer(OP_TICK, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
		// zero count holds a slot forever; max count; stop of a live periodic slot
		offer(OP_START_ONE, '0, '0, 16'h00AA);
		offer(OP_START_PER, 32'hFFFF_FFFF, '0, 16'h5500);
		offer(OP_STOP, '0, 8'd1, '0);
		offer(OP_STOP, '0, 8'(NumSlots), '0);
		offer(OP_TICK, '0, '0, '0);

		repeat (RandomCmds) random_command();
		s_tvalid <= 1'b0;

		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (2 * NumSlots + 8) @(posedge clk);

		$display("ran %0d commands: %0d starts (%0d on a full bank), %0d stops (%0d refused)",
			sent_count, sb.starts, sb.full_replies, sb.stops, sb.refused_stops);
		$display("%0d ticks raised %0d expiries; %0d mismatches", sb.ticks, sb.expiries, sb.errors);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
